// ===== rtl/core/savgol_vector_fir_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the smoothing filter core
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SAVGOL_VECTOR_FIR_FILTER_CORE_ASSERT_SVH
`define SAVGOL_VECTOR_FIR_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SGF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgf: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define SGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgf: next-cycle check failed");

`endif

// ===== rtl/core/sgf_pkg.sv =====
// ----------------------------------------------------------------------------
// Smoothing filter package
// Field widths, request codes, state types and the back-end status bundle.
// ----------------------------------------------------------------------------
package sgf_pkg;

    // Fixed field widths of the request and configuration ports.
    localparam int WIDX_W   = 5;
    localparam int WEIGHT_W = 19;
    localparam int HW_W     = 4;
    localparam int LANES    = 3;

    localparam logic [HW_W-1:0] HW_RESET = HW_W'(2);

    // Request kinds.
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DRAIN,
        B_FINISH
    } t_back_state;

    // Status of the multiply-accumulate back end as seen by the front end.
    typedef struct packed {
        logic reading;
    } t_back_status;

endpackage

// ===== rtl/core/sgf_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying weight writes and samples into the core.
// ----------------------------------------------------------------------------
interface sgf_req_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [sgf_pkg::WIDX_W-1:0]          weight_index;
    logic signed [sgf_pkg::WEIGHT_W-1:0] weight_value;
    logic signed [SAMPLE_BITS-1:0]       sample_x;
    logic signed [SAMPLE_BITS-1:0]       sample_y;
    logic signed [SAMPLE_BITS-1:0]       sample_z;
    logic                                end_of_sequence;

    modport source (
        output valid, kind, weight_index, weight_value,
               sample_x, sample_y, sample_z, end_of_sequence,
        input  ready
    );

    modport sink (
        input  valid, kind, weight_index, weight_value,
               sample_x, sample_y, sample_z, end_of_sequence,
        output ready
    );
endinterface

// ===== rtl/core/sgf_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying smoothed or passed-through samples out.
// ----------------------------------------------------------------------------
interface sgf_res_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic signed [SAMPLE_BITS-1:0] out_z;
    logic                          was_filtered;
    logic                          out_last;

    modport source (
        output valid, out_x, out_y, out_z, was_filtered, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, was_filtered, out_last,
        output ready
    );
endinterface

// ===== rtl/core/sgf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read; the read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sgf_front.sv =====
// ----------------------------------------------------------------------------
// Smoothing filter front end
// Accepts requests, writes weights and history, and queues one job per result.
// ----------------------------------------------------------------------------
module sgf_front #(
    parameter int MAX_HALF_WINDOW = 15,
    parameter int SAMPLE_BITS     = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    sgf_req_if.sink                                     i_req,
    input  logic                                        i_cfg_wr_en,
    input  logic [sgf_pkg::HW_W-1:0]                    i_cfg_wr_data,
    input  sgf_pkg::t_back_status                       i_back_status,
    input  logic                                        i_fifo_empty,
    input  logic                                        i_fifo_full,
    output logic                                        o_job_push,
    output logic [2+2*$clog2(2*MAX_HALF_WINDOW+1)-1:0]  o_job,
    output logic                                        o_weight_we,
    output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]      o_weight_addr,
    output logic [sgf_pkg::WEIGHT_W-1:0]                o_weight_data,
    output logic                                        o_hist_we,
    output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]      o_hist_addr,
    output logic [sgf_pkg::LANES*SAMPLE_BITS-1:0]       o_hist_data
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int S_W   = $clog2(DEPTH + 1);

    sgf_pkg::t_front_state r_state, n_state;

    logic [sgf_pkg::HW_W-1:0] r_half_window;
    logic [S_W-1:0]           r_seen;
    logic [IDX_W-1:0]         r_newest;
    logic [S_W-1:0]           r_s;
    logic [S_W-1:0]           r_m;
    logic [S_W-1:0]           r_d;
    logic                     r_eos;

    logic             accept;
    logic             is_sample;
    logic [S_W-1:0]   m_eff;
    logic [S_W-1:0]   win;
    logic [S_W-1:0]   s_cur;
    logic [S_W-1:0]   s_next;
    logic [S_W-1:0]   first_d;
    logic [IDX_W-1:0] newest_inc;
    logic [S_W-1:0]   two_m;
    logic             job_filt;
    logic             job_last;
    logic [IDX_W-1:0] job_off;
    logic [IDX_W:0]   base_wide;
    logic [IDX_W-1:0] job_base;
    logic [IDX_W-1:0] job_taps;

    // Handshake: a new request waits until no queued or running job reads memory.
    assign i_req.ready = (r_state == sgf_pkg::F_IDLE) && i_fifo_empty
                         && !i_back_status.reading;
    assign accept      = i_req.valid && i_req.ready;
    assign is_sample   = (i_req.kind == sgf_pkg::KIND_SAMPLE);

    // Effective half window, window size and clamped sample count.
    always_comb begin
        if (32'(r_half_window) > 32'(MAX_HALF_WINDOW)) begin
            m_eff = S_W'(MAX_HALF_WINDOW);
        end else begin
            m_eff = S_W'(r_half_window);
        end
        win        = S_W'({m_eff, 1'b1});
        s_cur      = (r_seen < win) ? r_seen : win;
        s_next     = (s_cur < win) ? s_cur + 1'b1 : win;
        first_d    = (s_cur < m_eff) ? s_cur : m_eff;
        newest_inc = (r_newest == IDX_W'(DEPTH - 1)) ? '0 : r_newest + 1'b1;
    end

    // Memory writes happen at the accepting edge.
    assign o_weight_we   = accept && !is_sample
                           && (32'(i_req.weight_index) < 32'(DEPTH));
    assign o_weight_addr = IDX_W'(i_req.weight_index);
    assign o_weight_data = i_req.weight_value;
    assign o_hist_we     = accept && is_sample;
    assign o_hist_addr   = newest_inc;
    assign o_hist_data   = {i_req.sample_x, i_req.sample_y, i_req.sample_z};

    // Job for the result that lags the newest sample by r_d positions.
    always_comb begin
        two_m     = r_m << 1;
        job_filt  = (r_d == r_m) && (r_s >= two_m);
        job_last  = r_eos && (r_d == '0);
        job_off   = job_filt ? IDX_W'(two_m) : IDX_W'(r_d);
        base_wide = {1'b0, r_newest} + (IDX_W + 1)'(DEPTH) - {1'b0, job_off};
        if ({1'b0, r_newest} >= {1'b0, job_off}) begin
            job_base = r_newest - job_off;
        end else begin
            job_base = base_wide[IDX_W-1:0];
        end
        job_taps  = job_filt ? IDX_W'(two_m) : '0;
    end

    assign o_job      = {job_filt, job_last, job_base, job_taps};
    assign o_job_push = (r_state == sgf_pkg::F_EMIT) && !i_fifo_full;

    // Next state: a sample that yields results moves to the emit state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgf_pkg::F_IDLE: begin
                if (accept && is_sample && (i_req.end_of_sequence || s_cur >= m_eff)) begin
                    n_state = sgf_pkg::F_EMIT;
                end
            end
            sgf_pkg::F_EMIT: begin
                if (o_job_push && (!r_eos || r_d == '0)) begin
                    n_state = sgf_pkg::F_IDLE;
                end
            end
            default: n_state = sgf_pkg::F_IDLE;
        endcase
    end

    // Control state: state, half window register, sample count, write pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sgf_pkg::F_IDLE;
            r_half_window <= sgf_pkg::HW_RESET;
            r_seen        <= '0;
            r_newest      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_half_window <= i_cfg_wr_data;
            end
            if (accept && is_sample) begin
                r_newest <= newest_inc;
                r_seen   <= i_req.end_of_sequence ? '0 : s_next;
            end
        end
    end

    // Per-sample job parameters and the countdown over pending results.
    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            r_s   <= s_cur;
            r_m   <= m_eff;
            r_eos <= i_req.end_of_sequence;
            r_d   <= i_req.end_of_sequence ? first_d : m_eff;
        end else if (o_job_push) begin
            r_d <= r_d - 1'b1;
        end
    end

endmodule

// ===== rtl/core/sgf_job_fifo.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Short register FIFO with fall-through read between front and back ends.
// ----------------------------------------------------------------------------
module sgf_job_fifo #(
    parameter int WIDTH   = 12,
    parameter int ENTRIES = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    wr_inc;
    logic [AW-1:0]    rd_inc;

    assign wr_inc  = (r_wr_ptr == AW'(ENTRIES - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_inc  = (r_rd_ptr == AW'(ENTRIES - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(ENTRIES));

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= wr_inc;
            end
            if (i_pop) begin
                r_rd_ptr <= rd_inc;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/sgf_back.sv =====
// ----------------------------------------------------------------------------
// Smoothing filter back end
// Runs one job at a time: one tap per cycle over three lanes, then rounds,
// saturates and places the result in the output register.
// ----------------------------------------------------------------------------
module sgf_back #(
    parameter int MAX_HALF_WINDOW  = 15,
    parameter int SAMPLE_BITS      = 32,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fifo_empty,
    input  logic [2+2*$clog2(2*MAX_HALF_WINDOW+1)-1:0]  i_job,
    output logic                                        o_pop,
    output logic                                        o_hist_re,
    output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]      o_hist_addr,
    input  logic [sgf_pkg::LANES*SAMPLE_BITS-1:0]       i_hist_data,
    output logic                                        o_weight_re,
    output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]      o_weight_addr,
    input  logic [sgf_pkg::WEIGHT_W-1:0]                i_weight_data,
    output sgf_pkg::t_back_status                       o_status,
    sgf_res_if.source                                   o_res
);

    localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int JOB_W  = 2 + 2 * IDX_W;
    localparam int LANES  = sgf_pkg::LANES;
    localparam int PROD_W = SAMPLE_BITS + sgf_pkg::WEIGHT_W;
    localparam int ACC_W  = PROD_W + $clog2(DEPTH) + 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    sgf_pkg::t_back_state r_state, n_state;

    logic             r_filt;
    logic             r_last;
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_left;
    logic             r_rd_vld;
    logic             r_mul_vld;
    logic             r_out_valid;
    logic             r_out_filt;
    logic             r_out_last;

    logic signed [PROD_W-1:0]      r_prod [LANES];
    logic signed [ACC_W-1:0]       r_acc  [LANES];
    logic [SAMPLE_BITS-1:0]        r_out  [LANES];
    logic signed [SAMPLE_BITS-1:0] hist_lane [LANES];
    logic signed [ACC_W-1:0]       rounded   [LANES];
    logic signed [ACC_W-1:0]       shifted   [LANES];
    logic [SAMPLE_BITS-1:0]        sat       [LANES];

    logic             issue;
    logic             out_free;
    logic             load_out;
    logic [IDX_W-1:0] addr_inc;

    // Job fields: filtered flag, last flag, first history address, tap count - 1.
    logic             job_filt;
    logic             job_last;
    logic [IDX_W-1:0] job_base;
    logic [IDX_W-1:0] job_taps;

    assign job_filt = i_job[JOB_W-1];
    assign job_last = i_job[JOB_W-2];
    assign job_base = i_job[2*IDX_W-1:IDX_W];
    assign job_taps = i_job[IDX_W-1:0];

    // Memory read issue, one tap per cycle.
    assign o_pop         = (r_state == sgf_pkg::B_IDLE) && !i_fifo_empty;
    assign issue         = (r_state == sgf_pkg::B_RUN);
    assign o_hist_re     = issue;
    assign o_hist_addr   = r_addr;
    assign o_weight_re   = issue;
    assign o_weight_addr = r_k;
    assign addr_inc      = (r_addr == IDX_W'(DEPTH - 1)) ? '0 : r_addr + 1'b1;

    assign out_free = !r_out_valid || o_res.ready;
    assign load_out = (r_state == sgf_pkg::B_FINISH) && out_free;

    assign o_status.reading = (r_state == sgf_pkg::B_RUN) || (r_state == sgf_pkg::B_DRAIN);

    // Lane split, rounding (half up) and saturation to the sample range.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            hist_lane[l] = i_hist_data[(LANES-1-l)*SAMPLE_BITS +: SAMPLE_BITS];
            rounded[l]   = r_acc[l] + ROUND_HALF;
            shifted[l]   = rounded[l] >>> WEIGHT_FRAC_BITS;
            if ((&shifted[l][ACC_W-1:SAMPLE_BITS-1]) || !(|shifted[l][ACC_W-1:SAMPLE_BITS-1])) begin
                sat[l] = shifted[l][SAMPLE_BITS-1:0];
            end else if (shifted[l][ACC_W-1]) begin
                sat[l] = SAT_MIN;
            end else begin
                sat[l] = SAT_MAX;
            end
        end
    end

    // Next state: issue taps, let the multiply-accumulate pipeline drain, finish.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgf_pkg::B_IDLE: begin
                if (o_pop) begin
                    n_state = sgf_pkg::B_RUN;
                end
            end
            sgf_pkg::B_RUN: begin
                if (r_left == '0) begin
                    n_state = sgf_pkg::B_DRAIN;
                end
            end
            sgf_pkg::B_DRAIN: begin
                if (!r_rd_vld && !r_mul_vld) begin
                    n_state = sgf_pkg::B_FINISH;
                end
            end
            sgf_pkg::B_FINISH: begin
                if (out_free) begin
                    n_state = sgf_pkg::B_IDLE;
                end
            end
            default: n_state = sgf_pkg::B_IDLE;
        endcase
    end

    // Control state: sequencer, pipeline valids and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgf_pkg::B_IDLE;
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= issue;
            r_mul_vld <= r_rd_vld;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job registers and tap counters.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_filt <= job_filt;
            r_last <= job_last;
            r_addr <= job_base;
            r_left <= job_taps;
            r_k    <= '0;
        end else if (issue) begin
            r_addr <= addr_inc;
            r_left <= r_left - 1'b1;
            r_k    <= r_k + 1'b1;
        end
    end

    // Three-lane multiply and accumulate.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (r_rd_vld) begin
                r_prod[l] <= hist_lane[l] * $signed(i_weight_data);
            end
            if (o_pop) begin
                r_acc[l] <= '0;
            end else if (r_mul_vld) begin
                r_acc[l] <= r_acc[l] + ACC_W'(r_prod[l]);
            end
        end
    end

    // Output register: window sum or the raw sample read for this job.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            for (int l = 0; l < LANES; l++) begin
                r_out[l] <= r_filt ? sat[l] : hist_lane[l];
            end
            r_out_filt <= r_filt;
            r_out_last <= r_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_x        = r_out[0];
    assign o_res.out_y        = r_out[1];
    assign o_res.out_z        = r_out[2];
    assign o_res.was_filtered = r_out_filt;
    assign o_res.out_last     = r_out_last;

endmodule

// ===== rtl/core/savgol_vector_fir_filter_core.sv =====
// ----------------------------------------------------------------------------
// Vector smoothing filter core
// Smooths a stream of three-component samples with a symmetric window of
// 2m+1 taps (m = half window register, reset 2). Requests on i_req either
// write one Q2.16 tap weight or deliver one sample; each result on o_res lags
// its sample by m, and results within m of either end of a sequence pass the
// raw sample through. The sample marked end_of_sequence flushes all pending
// results, the final one marked out_last. A weight write, or a sample that
// yields no result, lets the next request follow at once.
// A sample that yields results holds off the next request until its last job
// has left the memories. The single read port of the history and weight
// memories feeds one tap per cycle to the three multiply lanes, and the
// multiply-accumulate pipeline, through its read and multiply registers,
// drains before the result is rounded into the output register.
// A result left waiting in the output register does not hold the input, but
// any further job waits behind it.
// Weights and history need no clearing after reset; load the weights of the
// taps in use before the first sample.
// ----------------------------------------------------------------------------
`include "savgol_vector_fir_filter_core_assert.svh"

module savgol_vector_fir_filter_core #(
    parameter int MAX_HALF_WINDOW  = 15,
    parameter int SAMPLE_BITS      = 32,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sgf_req_if.sink                  i_req,
    sgf_res_if.source                o_res,
    input  logic                     i_cfg_wr_en,
    input  logic [sgf_pkg::HW_W-1:0] i_cfg_wr_data
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int JOB_W = 2 + 2 * IDX_W;
    localparam int HIST_W = sgf_pkg::LANES * SAMPLE_BITS;

    sgf_pkg::t_back_status back_status;

    logic                         job_push;
    logic [JOB_W-1:0]             job_in;
    logic [JOB_W-1:0]             job_out;
    logic                         job_pop;
    logic                         fifo_empty;
    logic                         fifo_full;
    logic                         weight_we;
    logic [IDX_W-1:0]             weight_waddr;
    logic [sgf_pkg::WEIGHT_W-1:0] weight_wdata;
    logic                         weight_re;
    logic [IDX_W-1:0]             weight_raddr;
    logic [sgf_pkg::WEIGHT_W-1:0] weight_rdata;
    logic                         hist_we;
    logic [IDX_W-1:0]             hist_waddr;
    logic [HIST_W-1:0]            hist_wdata;
    logic                         hist_re;
    logic [IDX_W-1:0]             hist_raddr;
    logic [HIST_W-1:0]            hist_rdata;

    // Front end: request intake, memory writes, job generation.
    sgf_front #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_back_status (back_status),
        .i_fifo_empty  (fifo_empty),
        .i_fifo_full   (fifo_full),
        .o_job_push    (job_push),
        .o_job         (job_in),
        .o_weight_we   (weight_we),
        .o_weight_addr (weight_waddr),
        .o_weight_data (weight_wdata),
        .o_hist_we     (hist_we),
        .o_hist_addr   (hist_waddr),
        .o_hist_data   (hist_wdata)
    );

    // Job queue between the two halves.
    sgf_job_fifo #(
        .WIDTH   (JOB_W),
        .ENTRIES (2)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    // Tap weight store.
    sgf_ram #(
        .WIDTH (sgf_pkg::WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (weight_we),
        .i_waddr (weight_waddr),
        .i_wdata (weight_wdata),
        .i_re    (weight_re),
        .i_raddr (weight_raddr),
        .o_rdata (weight_rdata)
    );

    // Sample history ring, all three components in one word.
    sgf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // Back end: multiply-accumulate, rounding, output register.
    sgf_back #(
        .MAX_HALF_WINDOW  (MAX_HALF_WINDOW),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_empty  (fifo_empty),
        .i_job         (job_out),
        .o_pop         (job_pop),
        .o_hist_re     (hist_re),
        .o_hist_addr   (hist_raddr),
        .i_hist_data   (hist_rdata),
        .o_weight_re   (weight_re),
        .o_weight_addr (weight_raddr),
        .i_weight_data (weight_rdata),
        .o_status      (back_status),
        .o_res         (o_res)
    );

    // A request never lands while the back end still reads the memories.
    `SGF_ASSERT_IMP(a_accept_no_read, i_clk, i_rst_n, i_req.valid && i_req.ready, !back_status.reading)

    // After a request the back end cannot have started reading.
    `SGF_ASSERT_NEXT(a_accept_then_quiet, i_clk, i_rst_n, i_req.valid && i_req.ready, !back_status.reading)

endmodule
